### sv/mqr_pkg.sv
// ----------------------------------------------------------------------------
// mqr_pkg: shared types and constants for the matrix quadrant rotator
// Payload structs for both channels, the configuration register indexes, and
// the request bundle that the sequencer hands to the element store.
// ----------------------------------------------------------------------------
package mqr_pkg;

	// Width of the rows and cols registers.
	localparam int CFG_W = 7;
	// Counters and flat addresses: rows * cols fits in twice the register width.
	localparam int CNT_W = 2 * CFG_W;
	// Width of the payload value fields.
	localparam int VAL_W = 32;

	// Reset value of both dimension registers.
	localparam logic [CFG_W-1:0] DIM_RESET = 7'd64;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_ROWS = 1'b0,
		REG_COLS = 1'b1
	} cfg_reg_t;

	// Operation codes carried in the func field.
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	// One input transaction.
	typedef struct packed {
		logic                    func;
		logic signed [VAL_W-1:0] value;
	} req_item_t;

	// One result transaction.
	typedef struct packed {
		logic signed [VAL_W-1:0] value_res;
		logic                    last;
		logic                    not_ready;
	} rsp_item_t;

	// Store accesses and result flags issued by the sequencer.
	typedef struct packed {
		logic             wr_en;
		logic [CNT_W-1:0] wr_addr;
		logic             rd_en;
		logic [CNT_W-1:0] rd_addr;
		logic             rsp_en;
		logic             last;
		logic             not_ready;
	} store_req_t;

endpackage

### sv/mqr_store.sv
// ----------------------------------------------------------------------------
// mqr_store: element store
// Single-clock memory with one write port and one read port. Read data is
// registered and holds its value until the next read.
// ----------------------------------------------------------------------------
module mqr_store #(
	parameter int DEPTH      = 4096,
	parameter int DATA_WIDTH = 32
) (
	input  logic                   clk,
	input  mqr_pkg::store_req_t    req,
	input  logic [DATA_WIDTH-1:0]  wr_data,
	output logic [DATA_WIDTH-1:0]  rd_data
);

	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [ADDR_W-1:0]     wr_idx;
	logic [ADDR_W-1:0]     rd_idx;

	// The flat addresses of enabled accesses are below DEPTH, so resizing keeps them intact.
	assign wr_idx = ADDR_W'(req.wr_addr);
	assign rd_idx = ADDR_W'(req.rd_addr);

	// Write port.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data <= mem[rd_idx];
		end
	end

endmodule

### sv/mqr_seq.sv
// ----------------------------------------------------------------------------
// mqr_seq: load and read sequencer
// Holds the dimension registers, the load counter and the row and column
// position of the read scan, and maps each read position to the flat address
// of its source element in the clockwise-rotated matrix.
// ----------------------------------------------------------------------------
module mqr_seq #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  mqr_pkg::cfg_reg_t           cfg_index,
	input  logic [mqr_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        accept,
	input  logic                        func,
	output mqr_pkg::store_req_t         req
);

	logic [mqr_pkg::CFG_W-1:0] rows_q;
	logic [mqr_pkg::CFG_W-1:0] cols_q;
	logic [mqr_pkg::CNT_W-1:0] load_q;
	logic [mqr_pkg::CFG_W-1:0] row_q;
	logic [mqr_pkg::CFG_W-1:0] col_q;

	logic [mqr_pkg::CFG_W-1:0] nr;
	logic [mqr_pkg::CFG_W-1:0] nc;
	logic [mqr_pkg::CFG_W-1:0] hh;
	logic [mqr_pkg::CFG_W-1:0] bot;
	logic [mqr_pkg::CFG_W-1:0] hw;
	logic [mqr_pkg::CFG_W-1:0] rgt;
	logic [mqr_pkg::CNT_W-1:0] total;
	logic                      full;
	logic [mqr_pkg::CFG_W-1:0] sr;
	logic [mqr_pkg::CFG_W-1:0] sc;
	logic                      at_end;
	logic                      is_load;
	logic                      is_read;

	// Effective dimensions: zero acts as one, oversize acts as the maximum.
	always_comb begin
		if (rows_q == '0) begin
			nr = mqr_pkg::CFG_W'(1);
		end else if (int'(rows_q) > MAX_ROWS) begin
			nr = mqr_pkg::CFG_W'(MAX_ROWS);
		end else begin
			nr = rows_q;
		end
		if (cols_q == '0) begin
			nc = mqr_pkg::CFG_W'(1);
		end else if (int'(cols_q) > MAX_COLS) begin
			nc = mqr_pkg::CFG_W'(MAX_COLS);
		end else begin
			nc = cols_q;
		end
	end

	// Quadrant boundaries and matrix size.
	assign hh    = nr >> 1;
	assign bot   = nr - hh;
	assign hw    = nc >> 1;
	assign rgt   = nc - hw;
	assign total = mqr_pkg::CNT_W'(nr) * mqr_pkg::CNT_W'(nc);
	assign full  = (load_q >= total);

	// Source position of the current read position after rotation.
	always_comb begin
		sr = row_q;
		sc = col_q;
		if (row_q < hh && col_q < hw) begin
			sr = row_q + bot;
		end else if (row_q >= bot && col_q < hw) begin
			sc = col_q + rgt;
		end else if (row_q >= bot && col_q >= rgt) begin
			sr = row_q - bot;
		end else if (row_q < hh && col_q >= rgt) begin
			sc = col_q - rgt;
		end
	end

	assign at_end  = (row_q == nr - 1'b1) && (col_q == nc - 1'b1);
	assign is_load = accept && (func == mqr_pkg::FUNC_LOAD);
	assign is_read = accept && (func == mqr_pkg::FUNC_READ);

	// Store accesses and result flags for this transaction.
	always_comb begin
		req.wr_en     = is_load && !full;
		req.wr_addr   = load_q;
		req.rd_en     = is_read && full;
		req.rd_addr   = mqr_pkg::CNT_W'(sr) * mqr_pkg::CNT_W'(nc)
		              + mqr_pkg::CNT_W'(sc);
		req.rsp_en    = is_read;
		req.last      = full && at_end;
		req.not_ready = !full;
	end

	// Dimension registers and counters; a register write restarts the load.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= mqr_pkg::DIM_RESET;
			cols_q <= mqr_pkg::DIM_RESET;
			load_q <= '0;
			row_q  <= '0;
			col_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mqr_pkg::REG_ROWS: rows_q <= cfg_data;
				mqr_pkg::REG_COLS: cols_q <= cfg_data;
				default: ;
			endcase
			load_q <= '0;
			row_q  <= '0;
			col_q  <= '0;
		end else if (req.wr_en) begin
			load_q <= load_q + 1'b1;
		end else if (req.rd_en) begin
			if (at_end) begin
				load_q <= '0;
				row_q  <= '0;
				col_q  <= '0;
			end else if (col_q == nc - 1'b1) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

### sv/matrix_quadrant_rotate.sv
// A read transaction's result passes through the store read and then the
// output register; loads give no result. Throughput: one transaction per
// cycle while req_stall is low, set by the single store write port and
// single registered read port. Reset clears the counters and sets both
// dimensions to 64 at once; the store is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
// matrix_quadrant_rotate: matrix loader with clockwise quadrant rotation
// Loads a matrix in row-major order into a memory, then streams it back in
// row-major order with its four quadrants rotated clockwise.
// ----------------------------------------------------------------------------
module matrix_quadrant_rotate #(
	parameter int MAX_ROWS   = 64,
	parameter int MAX_COLS   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  mqr_pkg::cfg_reg_t           cfg_index,
	input  logic [mqr_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  mqr_pkg::req_item_t          req,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output mqr_pkg::rsp_item_t          rsp
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;

	mqr_pkg::store_req_t   sreq;
	logic [DATA_WIDTH-1:0] wr_data;
	logic [DATA_WIDTH-1:0] rd_data;
	logic                  accept;
	logic                  advance;

	logic                  valid_s1;
	logic                  last_s1;
	logic                  not_ready_s1;
	logic                  rsp_valid_q;
	mqr_pkg::rsp_item_t    rsp_q;

	// Handshake: hold off new transactions only when both stages are full and the output is stalled.
	assign req_stall = valid_s1 && rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);

	// Stored elements keep only the low DATA_WIDTH bits of the value.
	assign wr_data = DATA_WIDTH'(unsigned'(req.value));

	mqr_seq #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.func      (req.func),
		.req       (sreq)
	);

	mqr_store #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_store (
		.clk     (clk),
		.req     (sreq),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	// Stage 1: read transaction waiting on store data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sreq.rsp_en) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sreq.rsp_en) begin
			last_s1      <= sreq.last;
			not_ready_s1 <= sreq.not_ready;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q.value_res <= not_ready_s1 ? '0 : mqr_pkg::VAL_W'(rd_data);
			rsp_q.last      <= last_s1;
			rsp_q.not_ready <= not_ready_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
